[hw/rtl/mshw_pkg.sv]
// ----------------------------------------------------------------------------
// mshw_pkg
// Shared constants and control types for the heartbeat watchdog.
// ----------------------------------------------------------------------------
package mshw_pkg;

  // Default number of supervised slots
  localparam int SLOT_COUNT_DEF = 8;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int ID_W   = 8;
  localparam int MASK_W = 8;
  localparam int CMD_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ARM       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVALUATE  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture the input item
    logic exec_write;  // apply an arm or heartbeat
    logic scan_step;   // issue one slot read of the evaluate scan
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             scan_last;
    logic             pipe_idle;
  } dp_status_t;

endpackage

[hw/rtl/mshw_ram.sv]
// ----------------------------------------------------------------------------
// mshw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mshw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mshw_ctrl.sv]
// ----------------------------------------------------------------------------
// mshw_ctrl
// Sequencer: accept a command, run the write or the slot scan, strobe result.
// ----------------------------------------------------------------------------
module mshw_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output logic                   out_valid,
  output mshw_pkg::ctrl_cmd_t    cmd_o,
  input  mshw_pkg::dp_status_t   status_i
);

  import mshw_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt        = state_r;
    cmd_o.latch      = 1'b0;
    cmd_o.exec_write = 1'b0;
    cmd_o.scan_step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.cmd == CMD_EVALUATE) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd_o.exec_write = 1'b1;
          state_nxt        = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_idle) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

[hw/rtl/mshw_dp.sv]
// ----------------------------------------------------------------------------
// mshw_dp
// Slot stores, flags and the three-stage evaluate pipeline.
// ----------------------------------------------------------------------------
module mshw_dp #(
  parameter int SLOT_COUNT = mshw_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mshw_pkg::ctrl_cmd_t           cmd_i,
  output mshw_pkg::dp_status_t          status_o,
  input  logic [mshw_pkg::CMD_W-1:0]    in_command,
  input  logic [mshw_pkg::ID_W-1:0]     in_slot_id,
  input  logic [mshw_pkg::DATA_W-1:0]   in_now_ms,
  input  logic [mshw_pkg::DATA_W-1:0]   in_epoch_ms,
  input  logic [mshw_pkg::DATA_W-1:0]   in_max_missed,
  input  logic [mshw_pkg::DATA_W-1:0]   in_grace_ms,
  output logic [mshw_pkg::MASK_W-1:0]   out_fault_mask,
  output logic [mshw_pkg::MASK_W-1:0]   out_new_fault_mask
);

  import mshw_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CFG_W = 3 * DATA_W;

  // Latched item
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [DATA_W-1:0] now_r, epoch_r, missed_r, grace_r;

  // Flags
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [SLOT_COUNT-1:0] seen_r, seen_nxt;
  logic [SLOT_COUNT-1:0] faulted_r, faulted_nxt;
  logic [MASK_W-1:0]     raised_r, raised_nxt;

  // Scan counter and pipeline
  logic [IDX_W-1:0]  cnt_r;
  logic              p1_vld_r, p2_vld_r, p3_vld_r;
  logic [IDX_W-1:0]  p1_idx_r, p2_idx_r, p3_idx_r;
  logic [DATA_W-1:0] p2_prod_r, p2_elapsed_r, p2_gadd_r;
  logic [DATA_W-1:0] p3_allow_r, p3_elapsed_r;
  logic              p3_fault;

  logic              id_ok;
  logic [IDX_W-1:0]  id_idx;
  logic              cfg_we, last_we;
  logic [CFG_W-1:0]  cfg_rdata;
  logic [DATA_W-1:0] last_rdata;
  logic [DATA_W-1:0] rd_epoch, rd_missed, rd_grace;

  assign id_ok  = (id_r < ID_W'(SLOT_COUNT));
  assign id_idx = id_r[IDX_W-1:0];

  assign cfg_we  = cmd_i.exec_write && id_ok && (cmd_r == CMD_ARM);
  assign last_we = cmd_i.exec_write && id_ok &&
                   ((cmd_r == CMD_ARM) || ((cmd_r == CMD_HEARTBEAT) && active_r[id_idx]));

  mshw_ram #(.WIDTH(CFG_W), .DEPTH(SLOT_COUNT)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (id_idx),
    .wdata ({epoch_r, missed_r, grace_r}),
    .raddr (cnt_r),
    .rdata (cfg_rdata)
  );

  mshw_ram #(.WIDTH(DATA_W), .DEPTH(SLOT_COUNT)) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (id_idx),
    .wdata (now_r),
    .raddr (cnt_r),
    .rdata (last_rdata)
  );

  assign rd_epoch  = cfg_rdata[CFG_W-1 -: DATA_W];
  assign rd_missed = cfg_rdata[2*DATA_W-1 -: DATA_W];
  assign rd_grace  = cfg_rdata[DATA_W-1:0];

  assign p3_fault = (p3_allow_r != '0) && (p3_elapsed_r >= p3_allow_r);

  always_comb begin
    active_nxt  = active_r;
    seen_nxt    = seen_r;
    faulted_nxt = faulted_r;
    raised_nxt  = raised_r;
    if (cmd_i.latch) begin
      raised_nxt = '0;
    end
    if (cmd_i.exec_write && id_ok) begin
      case (cmd_r)
        CMD_ARM: begin
          active_nxt[id_idx]  = 1'b1;
          seen_nxt[id_idx]    = 1'b0;
          faulted_nxt[id_idx] = 1'b0;
        end
        CMD_HEARTBEAT: begin
          if (active_r[id_idx]) begin
            seen_nxt[id_idx] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (p3_vld_r) begin
      if (p3_fault) begin
        if (!faulted_r[p3_idx_r]) begin
          faulted_nxt[p3_idx_r] = 1'b1;
          for (int k = 0; k < MASK_W; k++) begin
            if (k < SLOT_COUNT && p3_idx_r == IDX_W'(k)) begin
              raised_nxt[k] = 1'b1;
            end
          end
        end
      end else begin
        faulted_nxt[p3_idx_r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      seen_r    <= '0;
      faulted_r <= '0;
      raised_r  <= '0;
      cnt_r     <= '0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      seen_r    <= seen_nxt;
      faulted_r <= faulted_nxt;
      raised_r  <= raised_nxt;
      if (cmd_i.latch) begin
        cnt_r <= '0;
      end else if (cmd_i.scan_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      p1_vld_r <= cmd_i.scan_step;
      p2_vld_r <= p1_vld_r && active_r[p1_idx_r];
      p3_vld_r <= p2_vld_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      cmd_r    <= in_command;
      id_r     <= in_slot_id;
      now_r    <= in_now_ms;
      epoch_r  <= in_epoch_ms;
      missed_r <= in_max_missed;
      grace_r  <= in_grace_ms;
    end
    p1_idx_r     <= cnt_r;
    p2_idx_r     <= p1_idx_r;
    p2_prod_r    <= DATA_W'(rd_missed * rd_epoch);
    p2_elapsed_r <= now_r - last_rdata;
    p2_gadd_r    <= seen_r[p1_idx_r] ? '0 : rd_grace;
    p3_idx_r     <= p2_idx_r;
    p3_allow_r   <= p2_prod_r + p2_gadd_r;
    p3_elapsed_r <= p2_elapsed_r;
  end

  assign status_o.cmd       = cmd_r;
  assign status_o.scan_last = (cnt_r == IDX_W'(SLOT_COUNT - 1));
  assign status_o.pipe_idle = !p1_vld_r && !p2_vld_r && !p3_vld_r;

  for (genvar k = 0; k < MASK_W; k++) begin : g_mask
    if (k < SLOT_COUNT) begin : g_slot
      assign out_fault_mask[k] = faulted_r[k];
    end else begin : g_none
      assign out_fault_mask[k] = 1'b0;
    end
  end

  assign out_new_fault_mask = raised_r;

endmodule

[hw/rtl/multi_slot_heartbeat_watchdog.sv]
// ----------------------------------------------------------------------------
// multi_slot_heartbeat_watchdog
// Supervises a table of slots: arm, refresh by heartbeat, evaluate deadlines.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   ---------------------  ---------------------------------------
//   input     start & !busy          in_command, in_slot_id, in_now_ms,
//                                    in_epoch_ms, in_max_missed, in_grace_ms
//   result    out_valid (1 cycle)    out_fault_mask, out_new_fault_mask
//
// Arm, heartbeat and unknown commands go from the execute state to the done state, where the result is strobed.
// Evaluate scans one slot a cycle through a read, multiply, add pipeline, then
// drains; the drain lasts longest when the last slot is active.
// busy stays high through the result strobe; the next item can be taken in the cycle after it.
// Synchronous reset clears the active, seen and fault flags; the slot RAMs need
// no clearing as only the entries of armed slots are used. The receiver cannot stall.
//
module multi_slot_heartbeat_watchdog #(
  parameter int SLOT_COUNT = mshw_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mshw_pkg::CMD_W-1:0]    in_command,
  input  logic [mshw_pkg::ID_W-1:0]     in_slot_id,
  input  logic [mshw_pkg::DATA_W-1:0]   in_now_ms,
  input  logic [mshw_pkg::DATA_W-1:0]   in_epoch_ms,
  input  logic [mshw_pkg::DATA_W-1:0]   in_max_missed,
  input  logic [mshw_pkg::DATA_W-1:0]   in_grace_ms,
  output logic                          out_valid,
  output logic [mshw_pkg::MASK_W-1:0]   out_fault_mask,
  output logic [mshw_pkg::MASK_W-1:0]   out_new_fault_mask
);

  import mshw_pkg::*;

  // Command and status between sequencer and datapath
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // Sequence each item: latch, then write or scan, then strobe the result
  mshw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd_o     (ctrl_cmd),
    .status_i  (dp_status)
  );

  // Hold slot stores and flags; run the evaluate pipeline
  mshw_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .in_command         (in_command),
    .in_slot_id         (in_slot_id),
    .in_now_ms          (in_now_ms),
    .in_epoch_ms        (in_epoch_ms),
    .in_max_missed      (in_max_missed),
    .in_grace_ms        (in_grace_ms),
    .out_fault_mask     (out_fault_mask),
    .out_new_fault_mask (out_new_fault_mask)
  );

endmodule

[dv/mshw_result_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mshw_result_monitor
// Watches the command and result channels of the heartbeat watchdog, keeps
// its own copy of the slot table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module mshw_result_monitor #(
  parameter int SLOT_COUNT = mshw_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [mshw_pkg::CMD_W-1:0]    in_command,
  input  logic [mshw_pkg::ID_W-1:0]     in_slot_id,
  input  logic [mshw_pkg::DATA_W-1:0]   in_now_ms,
  input  logic [mshw_pkg::DATA_W-1:0]   in_epoch_ms,
  input  logic [mshw_pkg::DATA_W-1:0]   in_max_missed,
  input  logic [mshw_pkg::DATA_W-1:0]   in_grace_ms,
  input  logic                          out_valid,
  input  logic [mshw_pkg::MASK_W-1:0]   out_fault_mask,
  input  logic [mshw_pkg::MASK_W-1:0]   out_new_fault_mask,
  output int                            mismatch_count,
  output int                            results_pending
);

  import mshw_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef struct packed {
    logic [MASK_W-1:0] fault_mask;
    logic [MASK_W-1:0] new_fault_mask;
  } fault_result_t;

  logic [DATA_W-1:0]     epoch_tab     [SLOT_COUNT];
  logic [DATA_W-1:0]     missed_tab    [SLOT_COUNT];
  logic [DATA_W-1:0]     grace_tab     [SLOT_COUNT];
  logic [DATA_W-1:0]     last_seen_tab [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] active_flags;
  logic [SLOT_COUNT-1:0] seen_flags;
  logic [SLOT_COUNT-1:0] fault_flags;

  fault_result_t fault_results_due [$];
  fault_result_t want;
  int            results_seen;

  // Apply one item to the slot table and return the masks it should produce
  function automatic fault_result_t apply_item(
    input logic [CMD_W-1:0]  cmd,
    input logic [ID_W-1:0]   id,
    input logic [DATA_W-1:0] now,
    input logic [DATA_W-1:0] epoch,
    input logic [DATA_W-1:0] missed,
    input logic [DATA_W-1:0] grace
  );
    fault_result_t           res;
    logic [2*DATA_W-1:0]     product;
    logic [DATA_W-1:0]       allow;
    logic [DATA_W-1:0]       elapsed;
    logic [IDX_W-1:0]        idx;
    res = '0;
    idx = id[IDX_W-1:0];
    case (cmd)
      CMD_ARM: begin
        if (int'(id) < SLOT_COUNT) begin
          epoch_tab[idx]     = epoch;
          missed_tab[idx]    = missed;
          grace_tab[idx]     = grace;
          last_seen_tab[idx] = now;
          active_flags[idx]  = 1'b1;
          seen_flags[idx]    = 1'b0;
          fault_flags[idx]   = 1'b0;
        end
      end
      CMD_HEARTBEAT: begin
        if (int'(id) < SLOT_COUNT) begin
          if (active_flags[idx]) begin
            last_seen_tab[idx] = now;
            seen_flags[idx]    = 1'b1;
          end
        end
      end
      CMD_EVALUATE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (active_flags[i]) begin
            product = missed_tab[i] * epoch_tab[i];
            allow   = product[DATA_W-1:0];
            if (!seen_flags[i]) allow = allow + grace_tab[i];
            elapsed = now - last_seen_tab[i];
            if (allow != '0 && elapsed >= allow) begin
              if (!fault_flags[i]) begin
                fault_flags[i] = 1'b1;
                if (i < MASK_W) res.new_fault_mask[i] = 1'b1;
              end
            end else begin
              fault_flags[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    // Slots past the mask width are supervised but not reported
    for (int i = 0; i < SLOT_COUNT && i < MASK_W; i++) res.fault_mask[i] = fault_flags[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                 input logic [MASK_W-1:0] exp_val);
    $display("ERROR: result %0d: %s: got %02h, expected %02h", results_seen, what, got,
             exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      active_flags = '0;
      seen_flags   = '0;
      fault_flags  = '0;
      fault_results_due.delete();
      results_seen   = 0;
      mismatch_count = 0;
      results_pending <= 0;
    end else begin
      // Retire the result first: it belongs to an item accepted earlier
      if (out_valid) begin
        if (fault_results_due.size() == 0) begin
          report_mismatch("result with no item waiting", out_fault_mask, '0);
        end else begin
          want = fault_results_due.pop_front();
          if (out_fault_mask !== want.fault_mask)
            report_mismatch("fault_mask", out_fault_mask, want.fault_mask);
          if (out_new_fault_mask !== want.new_fault_mask)
            report_mismatch("new_fault_mask", out_new_fault_mask, want.new_fault_mask);
        end
        results_seen++;
      end
      if (start && !busy) begin
        fault_results_due.push_back(apply_item(in_command, in_slot_id, in_now_ms,
                                               in_epoch_ms, in_max_missed, in_grace_ms));
      end
      results_pending <= fault_results_due.size();
    end
  end

endmodule

[dv/tb_multi_slot_heartbeat_watchdog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_slot_heartbeat_watchdog
// Drives directed and random command items into the heartbeat watchdog, with
// random gaps, and reports the verdict counted by the result monitor.
// ----------------------------------------------------------------------------
module tb_multi_slot_heartbeat_watchdog;

  import mshw_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int ITEM_TARGET = 1850;
  // Slowest item is an evaluate plus the longest gap; allow many times over
  localparam int CYCLE_LIMIT = 1_000_000;
  // Command code with no meaning to the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_command;
  logic [ID_W-1:0]   in_slot_id;
  logic [DATA_W-1:0] in_now_ms;
  logic [DATA_W-1:0] in_epoch_ms;
  logic [DATA_W-1:0] in_max_missed;
  logic [DATA_W-1:0] in_grace_ms;
  logic              out_valid;
  logic [MASK_W-1:0] out_fault_mask;
  logic [MASK_W-1:0] out_new_fault_mask;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  int items_sent  = 0;
  bit burst_no_idle;
  logic [DATA_W-1:0] wall_ms;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multi_slot_heartbeat_watchdog #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_slot_id         (in_slot_id),
    .in_now_ms          (in_now_ms),
    .in_epoch_ms        (in_epoch_ms),
    .in_max_missed      (in_max_missed),
    .in_grace_ms        (in_grace_ms),
    .out_valid          (out_valid),
    .out_fault_mask     (out_fault_mask),
    .out_new_fault_mask (out_new_fault_mask)
  );

  mshw_result_monitor #(
    .SLOT_COUNT(SLOTS)
  ) i_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_slot_id         (in_slot_id),
    .in_now_ms          (in_now_ms),
    .in_epoch_ms        (in_epoch_ms),
    .in_max_missed      (in_max_missed),
    .in_grace_ms        (in_grace_ms),
    .out_valid          (out_valid),
    .out_fault_mask     (out_fault_mask),
    .out_new_fault_mask (out_new_fault_mask),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  // Watchdog on the testbench itself: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_multi_slot_heartbeat_watchdog failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none at all inside a tight burst
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_no_idle) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 60);
  endfunction

  // Present one item at the falling edge and hold it until the block takes it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [DATA_W-1:0] now, input logic [DATA_W-1:0] epoch,
                           input logic [DATA_W-1:0] missed, input logic [DATA_W-1:0] grace);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command    <= cmd;
    in_slot_id    <= id;
    in_now_ms     <= now;
    in_epoch_ms   <= epoch;
    in_max_missed <= missed;
    in_grace_ms   <= grace;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Drop start and hold off until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Slot id: mostly inside the table, sometimes just past it or far beyond
  function automatic logic [ID_W-1:0] pick_slot();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) return ID_W'($urandom_range(0, SLOTS - 1));
    if (roll < 95) return ID_W'(SLOTS);
    return ID_W'($urandom_range(SLOTS, 255));
  endfunction

  // One item of a plausible supervision sequence: time moves forward, slots
  // get armed with small periods, heartbeats come and go, evaluates poll
  task automatic send_scenario_item();
    int roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) wall_ms = wall_ms + $urandom_range(0, 12);
    else wall_ms = wall_ms + $urandom_range(13, 150);
    if (roll < 14) begin
      if ($urandom_range(0, 19) == 0)
        send_item(CMD_ARM, pick_slot(), wall_ms, $urandom, $urandom, $urandom);
      else
        send_item(CMD_ARM, pick_slot(), wall_ms, $urandom_range(0, 16),
                  $urandom_range(0, 5), $urandom_range(0, 40));
    end else if (roll < 55) begin
      // Arm-only fields carry noise; the block must ignore them
      send_item(CMD_HEARTBEAT, pick_slot(), wall_ms, $urandom, $urandom, $urandom);
    end else if (roll < 95) begin
      send_item(CMD_EVALUATE, ID_W'($urandom), wall_ms, $urandom, $urandom, $urandom);
    end else begin
      send_item(CMD_W'($urandom_range(0, 3)), ID_W'($urandom), $urandom, $urandom,
                $urandom, $urandom);
    end
  endtask

  initial begin
    int burst_len;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_ARM;
    in_slot_id    = '0;
    in_now_ms     = '0;
    in_epoch_ms   = '0;
    in_max_missed = '0;
    in_grace_ms   = '0;
    burst_no_idle = 1'b0;
    wall_ms       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, heartbeat to an inactive slot
    send_item(CMD_EVALUATE,  8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(CMD_HEARTBEAT, 8'd0, 32'd5, 32'd0, 32'd0, 32'd0);
    // Startup grace: allowance 3 * 10 + 5 from time 100
    send_item(CMD_ARM,       8'd0, 32'd100, 32'd10, 32'd3, 32'd5);
    send_item(CMD_EVALUATE,  8'd0, 32'd134, 32'd0, 32'd0, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'd135, 32'd0, 32'd0, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'd200, 32'd0, 32'd0, 32'd0);
    // After the first heartbeat the grace no longer counts
    send_item(CMD_HEARTBEAT, 8'd0, 32'd200, 32'd0, 32'd0, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'd229, 32'd0, 32'd0, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'd230, 32'd0, 32'd0, 32'd0);
    // Zero allowance from a zero epoch, and from a product plus grace that wraps
    send_item(CMD_ARM, 8'd7, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_ARM, 8'd1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_EVALUATE,  8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    // Ids outside the table, then the unused command with every bit set
    send_item(CMD_ARM,       8'(SLOTS), 32'd0, 32'd1, 32'd1, 32'd0);
    send_item(CMD_ARM,       8'hFF, 32'd0, 32'd1, 32'd1, 32'd0);
    send_item(CMD_HEARTBEAT, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_item(CMD_UNUSED,    8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    // Elapsed time across the wrap of now_ms
    send_item(CMD_ARM,       8'd2, 32'h8000_0000, 32'd1, 32'd1, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_item(CMD_HEARTBEAT, 8'd7, 32'h0000_0010, 32'd0, 32'd0, 32'd0);
    // Re-arming clears a held fault
    send_item(CMD_ARM,       8'd0, 32'd0, 32'd1, 32'd2, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_item(CMD_EVALUATE,  8'd0, 32'd1, 32'd0, 32'd0, 32'd0);
    drain_results();

    // Random bursts; each starts from a fresh uptime, sometimes near the wrap
    while (items_sent < ITEM_TARGET) begin
      burst_len     = $urandom_range(30, 120);
      burst_no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
      else wall_ms = $urandom;
      repeat (burst_len) send_scenario_item();
      burst_no_idle = 1'b0;
      if ($urandom_range(0, 1) == 0) drain_results();
    end

    drain_results();
    repeat (SLOTS + 10) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb_multi_slot_heartbeat_watchdog passed");
    end else begin
      $display("tb_multi_slot_heartbeat_watchdog failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mshw_pkg.sv
hw/rtl/mshw_ram.sv
hw/rtl/mshw_ctrl.sv
hw/rtl/mshw_dp.sv
hw/rtl/multi_slot_heartbeat_watchdog.sv
dv/mshw_result_monitor.sv
dv/tb_multi_slot_heartbeat_watchdog.sv
